@@ rtl/core/mre_pkg.sv @@
// Shared types, codes and small tables for the mouse report encoder.
package mre_pkg;

  // Widths of the coordinate ports, the button code and the field value
  localparam int COL_W   = 12;
  localparam int CODE_W  = 8;
  localparam int FIELD_W = 13;   // largest field: 4095 + 32
  localparam int POS_W   = 2;    // up to four decimal digits or three UTF-8 bytes

  // Event kinds
  localparam logic [1:0] CMD_PRESS   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_MOTION  = 2'd2;

  // Report characters
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_LBR  = 8'h5B;  // '['
  localparam logic [7:0] CH_LT   = 8'h3C;  // '<'
  localparam logic [7:0] CH_SEMI = 8'h3B;  // ';'
  localparam logic [7:0] CH_UPM  = 8'h4D;  // 'M'
  localparam logic [7:0] CH_LOWM = 8'h6D;  // 'm'
  localparam logic [7:0] CH_ZERO = 8'h30;  // '0'

  // Report format register codes
  typedef enum logic [1:0] {
    FMT_X10   = 2'd0,
    FMT_UTF8  = 2'd1,
    FMT_SGR   = 2'd2,
    FMT_URXVT = 2'd3
  } fmt_t;

  // Serialiser steps
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ESC,
    ST_LBR,
    ST_PREFIX,
    ST_F0,
    ST_SEP0,
    ST_F1,
    ST_SEP1,
    ST_F2,
    ST_TERM
  } step_t;

  // Event handed from the input register to the serialiser
  typedef struct packed {
    logic              valid;
    logic              ok;      // button valid, report to be sent
    logic              rel;
    logic [CODE_W-1:0] code;
    logic [COL_W-1:0]  col;
    logic [COL_W-1:0]  row;
  } evt_t;

  // Button 1..9 to base code
  function automatic logic [CODE_W-1:0] btn_code(input logic [3:0] btn);
    logic [CODE_W-1:0] c;
    case (btn)
      4'd1:    c = 8'd0;
      4'd2:    c = 8'd1;
      4'd3:    c = 8'd2;
      4'd4:    c = 8'd64;
      4'd5:    c = 8'd65;
      4'd6:    c = 8'd66;
      4'd7:    c = 8'd67;
      4'd8:    c = 8'd128;
      4'd9:    c = 8'd129;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // m times ten to the power k, for the digit compare
  function automatic logic [FIELD_W:0] dec_mult(input logic [POS_W-1:0] k,
                                                input logic [3:0] m);
    logic [FIELD_W:0] p;
    case (k)
      2'd0:    p = 14'd1;
      2'd1:    p = 14'd10;
      2'd2:    p = 14'd100;
      2'd3:    p = 14'd1000;
      default: p = 14'd1;
    endcase
    return (FIELD_W + 1)'(p * {10'd0, m});
  endfunction

endpackage

@@ rtl/core/mre_event_stage.sv @@
// Input register and button code formation.
module mre_event_stage #(
  parameter int COORD_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mre_pkg::fmt_t             fmt,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                command,
  input  logic [2:0]                modifier_keys,
  input  logic [3:0]                motion_button,
  input  logic [3:0]                button,
  input  logic [mre_pkg::COL_W-1:0] column,
  input  logic [mre_pkg::COL_W-1:0] row,
  input  logic                      take,
  output mre_pkg::evt_t             evt
);
  import mre_pkg::*;

  localparam int KeepBits = (COORD_BITS < COL_W) ? COORD_BITS : COL_W;
  localparam logic [COL_W-1:0] CoordMask = COL_W'((33'd1 << KeepBits) - 33'd1);

  logic              a_valid;
  logic [1:0]        a_cmd;
  logic [2:0]        a_mods;
  logic [3:0]        a_mbtn;
  logic [3:0]        a_btn;
  logic [COL_W-1:0]  a_col;
  logic [COL_W-1:0]  a_row;
  logic [CODE_W-1:0] base;
  logic              ok;

  assign in_ready = !a_valid || take;

  // Event register, refilled as soon as the serialiser takes the held beat
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      a_cmd  <= command;
      a_mods <= modifier_keys;
      a_mbtn <= motion_button;
      a_btn  <= button;
      a_col  <= column & CoordMask;
      a_row  <= row & CoordMask;
    end
  end

  // Base button code; release outside SGR ignores the button field
  always_comb begin
    ok   = 1'b1;
    base = 8'd35;
    if (a_cmd == CMD_MOTION) begin
      if (a_mbtn >= 4'd1 && a_mbtn <= 4'd3) base = 8'd31 + {4'd0, a_mbtn};
      else base = 8'd35;
    end else if (a_cmd == CMD_RELEASE && fmt != FMT_SGR) begin
      base = 8'd3;
    end else begin
      ok   = (a_btn >= 4'd1) && (a_btn <= 4'd9);
      base = btn_code(a_btn);
    end
  end

  // Modifiers add 4, 8 and 16
  always_comb begin
    evt.valid = a_valid;
    evt.ok    = ok;
    evt.rel   = (a_cmd == CMD_RELEASE);
    evt.code  = base + {3'd0, a_mods[2], a_mods[1], a_mods[0], 2'd0};
    evt.col   = a_col;
    evt.row   = a_row;
  end

endmodule

@@ rtl/core/mre_serializer.sv @@
// Report sequencer: walks the report one byte per cycle while out_free, decimal digits by compare.
module mre_serializer (
  input  logic          clk,
  input  logic          rst,
  input  mre_pkg::fmt_t fmt,
  input  mre_pkg::evt_t evt,
  output logic          take,
  input  logic          out_free,
  output logic          push,
  output logic [7:0]    push_byte,
  output logic          push_last
);
  import mre_pkg::*;

  step_t              step, step_next;
  logic               rel;
  logic [CODE_W-1:0]  code;
  logic [COL_W-1:0]   col;
  logic [COL_W-1:0]   row;
  logic [FIELD_W-1:0] fval, fval_next;
  logic [POS_W-1:0]   fpos, fpos_next;

  logic               dec;
  logic               adv;
  logic               fdone;
  logic [FIELD_W-1:0] raw;
  logic               off;
  logic [FIELD_W-1:0] val_in;
  logic [POS_W-1:0]   start_pos;
  logic [8:0]         ge;
  logic [3:0]         digit;
  logic [FIELD_W:0]   sub;
  logic [FIELD_W-1:0] rem;
  logic [7:0]         utf_byte;
  logic [7:0]         field_byte;
  logic               ser_free;

  assign dec   = (fmt == FMT_SGR) || (fmt == FMT_URXVT);
  assign adv   = (step != ST_IDLE) && out_free;
  assign fdone = (fpos == '0);
  assign push  = adv;

  // Value of the field about to start
  always_comb begin
    case (step)
      ST_LBR, ST_PREFIX: begin
        raw = {{(FIELD_W-CODE_W){1'b0}}, code};
        off = (fmt != FMT_SGR);
      end
      ST_F0, ST_SEP0: begin
        raw = {{(FIELD_W-COL_W){1'b0}}, col};
        off = !dec;
      end
      default: begin
        raw = {{(FIELD_W-COL_W){1'b0}}, row};
        off = !dec;
      end
    endcase
    val_in = raw + (off ? FIELD_W'(32) : FIELD_W'(0));
  end

  // First byte position of that field
  always_comb begin
    case (fmt)
      FMT_X10:  start_pos = 2'd0;
      FMT_UTF8: begin
        if (val_in >= FIELD_W'(2048))     start_pos = 2'd2;
        else if (val_in >= FIELD_W'(128)) start_pos = 2'd1;
        else                              start_pos = 2'd0;
      end
      default: begin
        if (val_in >= FIELD_W'(1000))     start_pos = 2'd3;
        else if (val_in >= FIELD_W'(100)) start_pos = 2'd2;
        else if (val_in >= FIELD_W'(10))  start_pos = 2'd1;
        else                              start_pos = 2'd0;
      end
    endcase
  end

  // Leading decimal digit: parallel compares against m * 10^k
  always_comb begin
    for (int m = 1; m <= 9; m++) begin
      ge[m-1] = {1'b0, fval} >= dec_mult(fpos, 4'(m));
    end
    digit = 4'd0;
    for (int i = 0; i < 9; i++) begin
      digit = digit + {3'd0, ge[i]};
    end
    sub = dec_mult(fpos, digit);
    rem = fval - sub[FIELD_W-1:0];
  end

  // UTF-8 byte at the current position
  always_comb begin
    case (fpos)
      2'd2: utf_byte = {4'b1110, 3'b000, fval[12]};
      2'd1: begin
        if (fval >= FIELD_W'(2048)) utf_byte = {2'b10, fval[11:6]};
        else                        utf_byte = {3'b110, fval[10:6]};
      end
      default: begin
        if (fval >= FIELD_W'(128)) utf_byte = {2'b10, fval[5:0]};
        else                       utf_byte = {1'b0, fval[6:0]};
      end
    endcase
    case (fmt)
      FMT_X10:  field_byte = fval[7:0];
      FMT_UTF8: field_byte = utf_byte;
      default:  field_byte = CH_ZERO + {4'd0, digit};
    endcase
  end

  // Byte and last flag for the current step
  always_comb begin
    push_last = 1'b0;
    case (step)
      ST_ESC:    push_byte = CH_ESC;
      ST_LBR:    push_byte = CH_LBR;
      ST_PREFIX: push_byte = (fmt == FMT_SGR) ? CH_LT : CH_UPM;
      ST_SEP0,
      ST_SEP1:   push_byte = CH_SEMI;
      ST_TERM: begin
        push_byte = (fmt == FMT_SGR && rel) ? CH_LOWM : CH_UPM;
        push_last = 1'b1;
      end
      ST_F0, ST_F1: push_byte = field_byte;
      ST_F2: begin
        push_byte = field_byte;
        push_last = fdone && !dec;
      end
      default:   push_byte = CH_ESC;
    endcase
  end

  assign ser_free = (step == ST_IDLE) || (adv && push_last);
  assign take     = evt.valid && ser_free;

  // Step sequencing and field walking
  always_comb begin
    step_next = step;
    fval_next = fval;
    fpos_next = fpos;
    if (adv) begin
      case (step)
        ST_ESC: step_next = ST_LBR;
        ST_LBR: begin
          if (fmt == FMT_URXVT) begin
            step_next = ST_F0;
            fval_next = val_in;
            fpos_next = start_pos;
          end else begin
            step_next = ST_PREFIX;
          end
        end
        ST_PREFIX, ST_SEP0, ST_SEP1: begin
          step_next = (step == ST_PREFIX) ? ST_F0 :
                      (step == ST_SEP0)   ? ST_F1 : ST_F2;
          fval_next = val_in;
          fpos_next = start_pos;
        end
        ST_F0, ST_F1, ST_F2: begin
          if (!fdone) begin
            fpos_next = fpos - 2'd1;
            if (dec) fval_next = rem;
          end else if (step == ST_F2) begin
            step_next = dec ? ST_TERM : ST_IDLE;
          end else if (dec) begin
            step_next = (step == ST_F0) ? ST_SEP0 : ST_SEP1;
          end else begin
            step_next = (step == ST_F0) ? ST_F1 : ST_F2;
            fval_next = val_in;
            fpos_next = start_pos;
          end
        end
        ST_TERM: step_next = ST_IDLE;
        default: step_next = step;
      endcase
    end
    // A new report starts as the previous one ends
    if (take) begin
      step_next = evt.ok ? ST_ESC : ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
    fval <= fval_next;
    fpos <= fpos_next;
    if (take) begin
      rel  <= evt.rel;
      code <= evt.code;
      col  <= evt.col;
      row  <= evt.row;
    end
  end

endmodule

@@ rtl/core/mre_out_stage.sv @@
// Output register for the byte stream.
module mre_out_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] push_byte,
  input  logic       push_last,
  output logic       out_free,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast
);

  assign out_free = !m_tvalid || m_tready;

  // Load a new beat whenever the held one is gone or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= push;
    end
    if (out_free && push) begin
      m_tdata <= push_byte;
      m_tlast <= push_last;
    end
  end

endmodule

@@ rtl/core/mouse_report_encoder_top.sv @@
// Mouse report encoder: pointer events in, terminal report bytes out.
// The first byte goes through the event, serialiser step and output registers.
// Throughput: one byte per cycle unless m_tready stalls the output; the next
// report starts as the previous one pushes its last byte; a dropped event sends none.
// Reset: synchronous, clears the format register to X10 and empties all stages.
module mouse_report_encoder_top #(
  parameter int COORD_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: command[1:0], modifier_keys[4:2], motion_button[8:5], button[12:9],
  //          column[24:13], row[36:25], zero[39:37]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  // m_tdata: out_byte[7:0]; m_tlast carries last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  output logic        m_tlast,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mre_pkg::*;

  fmt_t       fmt;
  evt_t       evt;
  logic       take;
  logic       out_free;
  logic       push;
  logic [7:0] push_byte;
  logic       push_last;

  // Format register; single register, so every address maps to it
  assign pready = 1'b1;
  assign prdata = {30'd0, fmt};

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= FMT_X10;
    end else if (psel && penable && pwrite && pready && paddr[1:0] <= 2'd3) begin
      fmt <= fmt_t'(pwdata[1:0]);
    end
  end

  mre_event_stage #(
    .COORD_BITS (COORD_BITS)
  ) u_event (
    .clk           (clk),
    .rst           (rst),
    .fmt           (fmt),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .command       (s_tdata[1:0]),
    .modifier_keys (s_tdata[4:2]),
    .motion_button (s_tdata[8:5]),
    .button        (s_tdata[12:9]),
    .column        (s_tdata[24:13]),
    .row           (s_tdata[36:25]),
    .take          (take),
    .evt           (evt)
  );

  mre_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .fmt       (fmt),
    .evt       (evt),
    .take      (take),
    .out_free  (out_free),
    .push      (push),
    .push_byte (push_byte),
    .push_last (push_last)
  );

  mre_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_byte (push_byte),
    .push_last (push_last),
    .out_free  (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
